// ===== rtl/core/rc4_pkg.sv =====
// ============================================================================
// RC4 package
// Shared types and constants for the RC4 stream cipher unit.
// ============================================================================
package rc4_pkg;

   localparam int RC4_KEY_MAX_BYTES = 256;
   localparam int RC4_PERM_DEPTH    = 256;

   localparam logic RC4_REQ_KEY  = 1'b0;
   localparam logic RC4_REQ_DATA = 1'b1;

   localparam logic RC4_STATUS_OK     = 1'b0;
   localparam logic RC4_STATUS_NO_KEY = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] byte_in;
      logic       key_last;
   } rc4_req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       status;
   } rc4_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_MIX_RD,
      ST_MIX_SUM,
      ST_MIX_WR_N,
      ST_MIX_WR_A,
      ST_GEN_I,
      ST_GEN_J,
      ST_GEN_WR_I,
      ST_GEN_WR_J,
      ST_GEN_OUT,
      ST_DONE
   } rc4_state_type;

endpackage

// ===== rtl/core/rc4_stream_cipher_unit.sv =====
// ============================================================================
// RC4 stream cipher unit
// Key loading, key schedule and keystream generation around one
// permutation memory with one write and one read port, driven by a small sequencer.
// ============================================================================
// Usage: the req channel carries key bytes and data bytes. Key bytes are
// stored in arrival order and produce no rsp transaction. The key byte that
// carries key_last starts the key schedule: it loads the identity permutation
// and then runs swap steps through MIX_RD, MIX_SUM, MIX_WR_N and MIX_WR_A.
// Each data byte produces one rsp transaction with the byte XORed with the
// next keystream byte. A data byte passes through GEN_I, GEN_J, GEN_WR_I,
// GEN_WR_J, GEN_OUT and DONE before its result enters the output register;
// the permutation memory, with registered read data, sets that sequence. A
// data byte that arrives before any key schedule returns zero with status
// set. A key byte without key_last leaves the unit idle. The unit handles
// one transaction at a time and holds req_stall high while it works. When
// rsp_stall holds an earlier result in the output register, the new result
// waits in DONE and the sequencer waits with it. Reset clears the control
// state, key length, indices and key ready flag; memories are not cleared.
// ============================================================================
module rc4_stream_cipher_unit #(
   parameter int KEY_MAX_BYTES = rc4_pkg::RC4_KEY_MAX_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rc4_pkg::rc4_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rc4_pkg::rc4_rsp_type rsp_payload
);
   import rc4_pkg::*;

   localparam int KLW = $clog2(KEY_MAX_BYTES + 1);
   localparam int KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

   rc4_state_type state_ff, state_in;

   logic [7:0]     perm_mem [RC4_PERM_DEPTH];
   logic [7:0]     key_mem  [KEY_MAX_BYTES];

   logic           perm_we;
   logic [7:0]     perm_wa;
   logic [7:0]     perm_wd;
   logic [7:0]     perm_ra;
   logic [7:0]     perm_rd_ff;
   logic           key_we;
   logic [7:0]     key_rd_ff;

   logic [KLW-1:0] key_len_ff, key_len_in;
   logic [KAW-1:0] kpos_ff, kpos_in;
   logic [KLW-1:0] kpos_inc;
   logic [7:0]     n_ff, n_in;
   logic [7:0]     acc_ff, acc_in;
   logic [7:0]     idx_i_ff, idx_i_in;
   logic [7:0]     idx_j_ff, idx_j_in;
   logic [7:0]     si_ff, si_in;
   logic [7:0]     sj_ff, sj_in;
   logic           bypass_ff, bypass_in;
   logic           key_ready_ff, key_ready_in;
   logic [7:0]     data_ff, data_in;
   rc4_rsp_type    res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rc4_rsp_type    rsp_ff, rsp_in;

   logic           req_accept;
   logic           key_room;
   logic           out_free;
   logic [7:0]     acc_sum;
   logic [7:0]     ks_sum;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign key_room    = (key_len_ff < KLW'(KEY_MAX_BYTES));
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign key_we      = req_accept && (req_payload.req_type == RC4_REQ_KEY) && key_room;
   assign kpos_inc    = KLW'(kpos_ff) + KLW'(1'b1);
   assign acc_sum     = acc_ff + perm_rd_ff + key_rd_ff;
   assign ks_sum      = si_ff + sj_ff;

   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_wa] <= perm_wd;
      end
      perm_rd_ff <= perm_mem[perm_ra];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_len_ff[KAW-1:0]] <= req_payload.byte_in;
      end
      key_rd_ff <= key_mem[kpos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_len_in   = key_len_ff;
      kpos_in      = kpos_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      idx_i_in     = idx_i_ff;
      idx_j_in     = idx_j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      bypass_in    = bypass_ff;
      key_ready_in = key_ready_ff;
      data_in      = data_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      perm_we      = 1'b0;
      perm_wa      = n_ff;
      perm_wd      = n_ff;
      perm_ra      = n_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               data_in = req_payload.byte_in;
               if (req_payload.req_type == RC4_REQ_KEY) begin
                  if (key_room) begin
                     key_len_in = key_len_ff + KLW'(1'b1);
                  end
                  if (req_payload.key_last) begin
                     n_in     = '0;
                     state_in = ST_INIT;
                  end
               end else if (!key_ready_ff) begin
                  res_in   = '{byte_out: 8'h00, status: RC4_STATUS_NO_KEY};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_GEN_I;
               end
            end
         end
         ST_INIT: begin
            perm_we = 1'b1;
            n_in    = n_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               acc_in   = '0;
               kpos_in  = '0;
               state_in = ST_MIX_RD;
            end
         end
         ST_MIX_RD: begin
            perm_ra  = n_ff;
            state_in = ST_MIX_SUM;
         end
         ST_MIX_SUM: begin
            si_in    = perm_rd_ff;
            acc_in   = acc_sum;
            perm_ra  = acc_sum;
            state_in = ST_MIX_WR_N;
         end
         ST_MIX_WR_N: begin
            perm_we  = 1'b1;
            perm_wa  = n_ff;
            perm_wd  = perm_rd_ff;
            state_in = ST_MIX_WR_A;
         end
         ST_MIX_WR_A: begin
            perm_we = 1'b1;
            perm_wa = acc_ff;
            perm_wd = si_ff;
            n_in    = n_ff + 8'd1;
            if (kpos_inc >= key_len_ff) begin
               kpos_in = '0;
            end else begin
               kpos_in = kpos_inc[KAW-1:0];
            end
            if (n_ff == 8'hFF) begin
               idx_i_in     = '0;
               idx_j_in     = '0;
               key_len_in   = '0;
               key_ready_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_MIX_RD;
            end
         end
         ST_GEN_I: begin
            idx_i_in = idx_i_ff + 8'd1;
            perm_ra  = idx_i_ff + 8'd1;
            state_in = ST_GEN_J;
         end
         ST_GEN_J: begin
            si_in    = perm_rd_ff;
            idx_j_in = idx_j_ff + perm_rd_ff;
            perm_ra  = idx_j_ff + perm_rd_ff;
            state_in = ST_GEN_WR_I;
         end
         ST_GEN_WR_I: begin
            sj_in    = perm_rd_ff;
            perm_we  = 1'b1;
            perm_wa  = idx_i_ff;
            perm_wd  = perm_rd_ff;
            state_in = ST_GEN_WR_J;
         end
         ST_GEN_WR_J: begin
            perm_we   = 1'b1;
            perm_wa   = idx_j_ff;
            perm_wd   = si_ff;
            perm_ra   = ks_sum;
            bypass_in = (ks_sum == idx_j_ff);
            state_in  = ST_GEN_OUT;
         end
         ST_GEN_OUT: begin
            res_in.byte_out = data_ff ^ (bypass_ff ? si_ff : perm_rd_ff);
            res_in.status   = RC4_STATUS_OK;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff   <= '0;
         idx_i_ff     <= '0;
         idx_j_ff     <= '0;
         key_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_len_ff   <= key_len_in;
         idx_i_ff     <= idx_i_in;
         idx_j_ff     <= idx_j_in;
         key_ready_ff <= key_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kpos_ff   <= kpos_in;
      n_ff      <= n_in;
      acc_ff    <= acc_in;
      si_ff     <= si_in;
      sj_ff     <= sj_in;
      bypass_ff <= bypass_in;
      data_ff   <= data_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      key_ready_ff |=> key_ready_ff)
      else $error("Key ready flag dropped after a key schedule.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN_I) |-> key_ready_ff)
      else $error("Keystream generation started without a scheduled key.");

   assert property (@(posedge clock) disable iff (reset)
      key_len_ff <= KLW'(KEY_MAX_BYTES))
      else $error("Key length exceeds the key store depth.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX_WR_A && n_ff == 8'hFF) |=>
         (key_len_ff == '0 && idx_i_ff == '0 && idx_j_ff == '0 && state_ff == ST_IDLE))
      else $error("Key schedule did not clear the key length and indices.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) |=> !rsp_valid_ff)
      else $error("Result transaction repeated after delivery.");

endmodule
